### sv/mswg_pkg.sv
`timescale 1ns / 1ps

package mswg_pkg;

    typedef enum logic [2:0] {
        WAVE_STOP   = 3'd0,
        WAVE_SINE   = 3'd1,
        WAVE_TRI    = 3'd2,
        WAVE_SQUARE = 3'd3,
        WAVE_STAIR  = 3'd4
    } wave_t;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SELECT  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FREQUENCY    = 8'd1;

    localparam int PHASE_W = 9;
    localparam int HOLD_W  = 9;

    localparam int FREQ_RESET      = 100;
    localparam int HALF_NUMERATOR  = 500;
    localparam int FREQ_CODES      = 256;

    localparam int TRI_LAST        = 511;
    localparam int SQUARE_LAST     = 1;

    localparam int SINE_TABLE_LEN = 36;
    localparam logic [7:0] SINE_TAB [SINE_TABLE_LEN] = '{
        8'd128, 8'd150, 8'd171, 8'd192, 8'd218, 8'd226, 8'd238, 8'd248, 8'd254,
        8'd255, 8'd254, 8'd248, 8'd238, 8'd226, 8'd210, 8'd192, 8'd171, 8'd150,
        8'd128, 8'd105, 8'd84,  8'd64,  8'd45,  8'd29,  8'd17,  8'd7,   8'd1,
        8'd0,   8'd1,   8'd7,   8'd17,  8'd29,  8'd45,  8'd64,  8'd84,  8'd105
    };

    localparam int STAIR_LEVELS = 11;
    localparam int STAIR_IDX_W  = $clog2(STAIR_LEVELS);
    localparam logic [7:0] STAIR_TAB [STAIR_LEVELS] = '{
        8'h00, 8'h33, 8'h66, 8'h99, 8'hCC, 8'hFF, 8'hCC, 8'h99, 8'h66, 8'h66, 8'h33
    };

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [HOLD_W-1:0]  hold;
    } wave_state_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       period_end;
    } wave_result_t;

endpackage

### sv/mswg_step.sv
`timescale 1ns / 1ps

module mswg_step #(
    parameter int SINE_POINTS      = 36,
    parameter int SINE_HOLD_TICKS  = 5,
    parameter int STAIR_HOLD_TICKS = 100
) (
    input  mswg_pkg::wave_t        wave,
    input  logic [8:0]             half_period,
    input  logic                   advance,
    input  mswg_pkg::wave_state_t  cur,
    output mswg_pkg::wave_state_t  nxt,
    output mswg_pkg::wave_result_t res
);

    localparam int SINE_IDX_W = $clog2(SINE_POINTS);

    logic [7:0] sine_rom [SINE_POINTS];

    for (genvar gi = 0; gi < SINE_POINTS; gi++) begin : g_sine
        localparam int ENTRY = (gi * mswg_pkg::SINE_TABLE_LEN) / SINE_POINTS;
        assign sine_rom[gi] = mswg_pkg::SINE_TAB[ENTRY];
    end

    logic                          active;
    logic [mswg_pkg::PHASE_W-1:0]  n_last;
    logic [mswg_pkg::HOLD_W-1:0]   h_last;
    logic [mswg_pkg::PHASE_W-1:0]  p;
    logic [mswg_pkg::HOLD_W-1:0]   h;

    always_comb begin
        active = 1'b1;
        n_last = '0;
        h_last = '0;
        case (wave)
            mswg_pkg::WAVE_SINE: begin
                n_last = mswg_pkg::PHASE_W'(SINE_POINTS - 1);
                h_last = mswg_pkg::HOLD_W'(SINE_HOLD_TICKS - 1);
            end
            mswg_pkg::WAVE_TRI: begin
                n_last = mswg_pkg::PHASE_W'(mswg_pkg::TRI_LAST);
            end
            mswg_pkg::WAVE_SQUARE: begin
                n_last = mswg_pkg::PHASE_W'(mswg_pkg::SQUARE_LAST);
                h_last = (half_period == '0) ? '0 : half_period - 9'd1;
            end
            mswg_pkg::WAVE_STAIR: begin
                n_last = mswg_pkg::PHASE_W'(mswg_pkg::STAIR_LEVELS - 1);
                h_last = mswg_pkg::HOLD_W'(STAIR_HOLD_TICKS - 1);
            end
            default: begin
                active = 1'b0;
            end
        endcase

        // out-of-range counters wrap to the start
        p = (cur.phase > n_last) ? '0 : cur.phase;
        h = (cur.hold > h_last) ? '0 : cur.hold;
    end

    always_comb begin
        res.sample = 8'd0;
        case (wave)
            mswg_pkg::WAVE_SINE:   res.sample = sine_rom[p[SINE_IDX_W-1:0]];
            mswg_pkg::WAVE_TRI:    res.sample = p[8] ? ~p[7:0] : p[7:0];
            mswg_pkg::WAVE_SQUARE: res.sample = (p == '0) ? 8'h00 : 8'hFF;
            mswg_pkg::WAVE_STAIR:  res.sample = mswg_pkg::STAIR_TAB[p[mswg_pkg::STAIR_IDX_W-1:0]];
            default:               res.sample = 8'd0;
        endcase
    end

    always_comb begin
        res.period_end = 1'b0;
        nxt            = cur;
        if (active) begin
            nxt.phase = p;
            nxt.hold  = h;
            if (advance) begin
                res.period_end = (p == n_last) && (h == h_last);
                if (h == h_last) begin
                    nxt.hold  = '0;
                    nxt.phase = (p == n_last) ? '0 : p + 9'd1;
                end else begin
                    nxt.hold  = h + 9'd1;
                end
            end
        end
    end

endmodule

### sv/multi_shape_waveform_generator.sv
`timescale 1ns / 1ps

// Waveform generator for an 8-bit DAC: each request with s_advance high is one
// microsecond tick and yields one sample (s_advance low repeats the sample).
// Modes are stop, sine, triangle, square and staircase, picked by config
// register 0; register 1 sets the square frequency in kHz. Every request gives
// exactly one result, and a request is taken every cycle while the result
// register is empty or being drained and no config write is offered: the
// counter update and the table lookup fit between the state registers and
// the single result register. The user must write configuration only while
// idle; the block itself does not enforce it. Any write of a known register
// restarts the waveform at its first sample.
module multi_shape_waveform_generator #(
    parameter int SINE_POINTS      = 36,
    parameter int SINE_HOLD_TICKS  = 5,
    parameter int STAIR_HOLD_TICKS = 100
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mswg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mswg_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_advance,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_sample,
    output logic                               m_period_end
);

    logic [8:0] half_rom [mswg_pkg::FREQ_CODES];

    for (genvar f = 0; f < mswg_pkg::FREQ_CODES; f++) begin : g_half
        localparam int DIVISOR = (f == 0) ? 1 : f;
        localparam int HALF    = mswg_pkg::HALF_NUMERATOR / DIVISOR;
        assign half_rom[f] = 9'(HALF);
    end

    logic [2:0]             wave_reg,   wave_next;
    logic [8:0]             half_reg,   half_next;
    mswg_pkg::wave_state_t  state_reg,  state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             sample_reg, sample_next;
    logic                   end_reg,    end_next;

    mswg_pkg::wave_state_t  step_state;
    mswg_pkg::wave_result_t step_res;

    logic cfg_fire;
    logic s_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (!m_valid_reg || m_ready) && !cfg_valid;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;

    mswg_step #(
        .SINE_POINTS      (SINE_POINTS),
        .SINE_HOLD_TICKS  (SINE_HOLD_TICKS),
        .STAIR_HOLD_TICKS (STAIR_HOLD_TICKS)
    ) u_step (
        .wave        (mswg_pkg::wave_t'(wave_reg)),
        .half_period (half_reg),
        .advance     (s_advance),
        .cur         (state_reg),
        .nxt         (step_state),
        .res         (step_res)
    );

    always_comb begin
        wave_next    = wave_reg;
        half_next    = half_reg;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        sample_next  = sample_reg;
        end_next     = end_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_fire) begin
            case (cfg_index)
                mswg_pkg::CFG_WAVE_SELECT: begin
                    wave_next  = cfg_data[2:0];
                    state_next = '0;
                end
                mswg_pkg::CFG_FREQUENCY: begin
                    half_next  = half_rom[cfg_data];
                    state_next = '0;
                end
                default: begin
                end
            endcase
        end else if (s_fire) begin
            state_next   = step_state;
            sample_next  = step_res.sample;
            end_next     = step_res.period_end;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg    <= mswg_pkg::WAVE_STOP;
            half_reg    <= 9'(mswg_pkg::HALF_NUMERATOR / mswg_pkg::FREQ_RESET);
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wave_reg    <= wave_next;
            half_reg    <= half_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        end_reg    <= end_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_sample     = sample_reg;
    assign m_period_end = end_reg;

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_fire && (cfg_index == mswg_pkg::CFG_WAVE_SELECT
                     || cfg_index == mswg_pkg::CFG_FREQUENCY)
        |=> state_reg.phase == '0 && state_reg.hold == '0)
        else $error("counters not cleared by config write");

    a_hold_no_end: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_advance |=> m_valid && !m_period_end)
        else $error("period_end without a tick");

    a_stop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !(wave_reg == mswg_pkg::WAVE_SINE || wave_reg == mswg_pkg::WAVE_TRI
                    || wave_reg == mswg_pkg::WAVE_SQUARE || wave_reg == mswg_pkg::WAVE_STAIR)
        |=> m_sample == 8'd0 && !m_period_end && $stable(state_reg))
        else $error("stop mode produced output or moved counters");

    a_half_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg != 9'd0)
        else $error("square half period is zero");

endmodule

### dv/multi_shape_waveform_generator_test.sv
`timescale 1ns / 1ps

module multi_shape_waveform_generator_test;

    localparam int SINE_PTS       = 36;
    localparam int SINE_HOLD      = 5;
    localparam int STAIR_HOLD     = 100;
    localparam int SINE_LUT_LEN   = 36;
    localparam int STAIR_LUT_LEN  = 11;
    localparam int TRI_STEPS      = 512;
    localparam int RAND_ITEMS     = 120;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int MAX_REPORTS    = 10;

    // index that maps to no register, and a selector code beyond the known modes
    localparam logic [7:0] CFG_NO_REG  = 8'hFF;
    localparam logic [7:0] SEL_UNKNOWN = 8'hFF;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] index;
        logic [7:0] data;
        logic       adv;
        logic       typed;
        logic [7:0] exp_sample;
        logic       exp_end;
    } stim_row_t;

    localparam int DIR_ROWS = 30;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
        '{ROW_WRITE, CFG_NO_REG, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_SINE), 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd128, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'd128, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_TRI), 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'd0, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'd1, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b0, 1'b1, 8'd2, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_FREQUENCY, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_SQUARE), 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'hFF, 1'b1},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_FREQUENCY, 8'd0, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_STAIR), 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, SEL_UNKNOWN, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_FREQUENCY, 8'd1, 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_WRITE, mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_SQUARE), 1'b0, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
        '{ROW_TICK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0}
    };

    logic [7:0] sine_lut [SINE_LUT_LEN] = '{
        8'd128, 8'd150, 8'd171, 8'd192, 8'd218, 8'd226, 8'd238, 8'd248, 8'd254,
        8'd255, 8'd254, 8'd248, 8'd238, 8'd226, 8'd210, 8'd192, 8'd171, 8'd150,
        8'd128, 8'd105, 8'd84,  8'd64,  8'd45,  8'd29,  8'd17,  8'd7,   8'd1,
        8'd0,   8'd1,   8'd7,   8'd17,  8'd29,  8'd45,  8'd64,  8'd84,  8'd105
    };

    logic [7:0] stair_lut [STAIR_LUT_LEN] = '{
        8'h00, 8'h33, 8'h66, 8'h99, 8'hCC, 8'hFF, 8'hCC, 8'h99, 8'h66, 8'h66, 8'h33
    };

    logic       aclk;
    logic       aresetn      = 1'b0;
    logic       cfg_valid    = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index    = 8'h00;
    logic [7:0] cfg_data     = 8'h00;
    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic       s_advance    = 1'b0;
    logic       m_valid;
    logic       m_ready      = 1'b0;
    logic [7:0] m_sample;
    logic       m_period_end;

    logic       tick_typed      = 1'b0;
    logic [7:0] tick_exp_sample = 8'h00;
    logic       tick_exp_end    = 1'b0;
    logic       idle_enable     = 1'b0;
    int         stall_left      = 0;

    logic [2:0] gen_sel;
    logic [7:0] gen_freq;
    logic [8:0] gen_phase;
    logic [8:0] gen_hold;
    logic [8:0] gen_half;

    mswg_pkg::wave_result_t expected_samples [$];
    int           mismatches  = 0;
    int           idle_cycles = 0;

    multi_shape_waveform_generator #(
        .SINE_POINTS      (SINE_PTS),
        .SINE_HOLD_TICKS  (SINE_HOLD),
        .STAIR_HOLD_TICKS (STAIR_HOLD)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_advance    (s_advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample     (m_sample),
        .m_period_end (m_period_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [8:0] half_of(input logic [7:0] f);
        int unsigned d;
        d = (f == 8'd0) ? 1 : f;
        return 9'(500 / d);
    endfunction

    function automatic void write_model(input logic [7:0] idx, input logic [7:0] val);
        if (idx == mswg_pkg::CFG_WAVE_SELECT) begin
            gen_sel = val[2:0];
        end else if (idx == mswg_pkg::CFG_FREQUENCY) begin
            gen_freq = val;
            gen_half = half_of(val);
        end else begin
            return;
        end
        gen_phase = '0;
        gen_hold  = '0;
    endfunction

    // step through npoints positions of hold_ticks each; 1 on the last tick of a period
    function automatic bit advance_position(input int unsigned npoints,
                                            input int unsigned hold_ticks,
                                            input logic adv);
        int unsigned hold;
        int unsigned ph;
        int unsigned hc;
        bit          last;
        hold = (hold_ticks == 0) ? 1 : hold_ticks;
        ph   = gen_phase;
        hc   = gen_hold;
        last = 1'b0;
        if (ph >= npoints) ph = 0;
        if (hc >= hold) hc = 0;
        if (adv) begin
            last = (ph == npoints - 1) && (hc == hold - 1);
            hc++;
            if (hc >= hold) begin
                hc = 0;
                ph++;
                if (ph >= npoints) ph = 0;
            end
        end
        gen_phase = 9'(ph);
        gen_hold  = 9'(hc);
        return last;
    endfunction

    function automatic mswg_pkg::wave_result_t next_sample(input logic adv);
        mswg_pkg::wave_result_t r;
        int unsigned  ph;
        int unsigned  e;
        ph           = gen_phase;
        r.sample     = 8'h00;
        r.period_end = 1'b0;
        case (gen_sel)
            mswg_pkg::WAVE_SINE: begin
                if (ph >= SINE_PTS) ph = 0;
                e = ph * SINE_LUT_LEN / SINE_PTS;
                if (e >= SINE_LUT_LEN) e = SINE_LUT_LEN - 1;
                gen_phase    = 9'(ph);
                r.sample     = sine_lut[e];
                r.period_end = advance_position(SINE_PTS, SINE_HOLD, adv);
            end
            mswg_pkg::WAVE_TRI: begin
                r.sample     = (ph < TRI_STEPS / 2) ? 8'(ph) : 8'(TRI_STEPS - 1 - ph);
                r.period_end = advance_position(TRI_STEPS, 1, adv);
            end
            mswg_pkg::WAVE_SQUARE: begin
                if (ph >= 2) ph = 0;
                gen_phase    = 9'(ph);
                r.sample     = (ph == 0) ? 8'h00 : 8'hFF;
                r.period_end = advance_position(2, gen_half, adv);
            end
            mswg_pkg::WAVE_STAIR: begin
                if (ph >= STAIR_LUT_LEN) ph = 0;
                gen_phase    = 9'(ph);
                r.sample     = stair_lut[ph];
                r.period_end = advance_position(STAIR_LUT_LEN, STAIR_HOLD, adv);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        mswg_pkg::wave_result_t exp_r;
        mswg_pkg::wave_result_t new_r;
        if (!aresetn) begin
            gen_sel   <= 3'(mswg_pkg::WAVE_STOP);
            gen_freq  <= 8'(mswg_pkg::FREQ_RESET);
            gen_phase <= '0;
            gen_hold  <= '0;
            gen_half  <= half_of(8'(mswg_pkg::FREQ_RESET));
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result: sample %0d period_end %0b",
                                 m_sample, m_period_end);
                    mismatches++;
                end else begin
                    exp_r = expected_samples.pop_front();
                    if (m_sample !== exp_r.sample || m_period_end !== exp_r.period_end) begin
                        if (mismatches < MAX_REPORTS)
                            $display("mismatch: sample exp %0d got %0d, period_end exp %0b got %0b",
                                     exp_r.sample, m_sample, exp_r.period_end, m_period_end);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                new_r = next_sample(s_advance);
                if (tick_typed) begin
                    new_r.sample     = tick_exp_sample;
                    new_r.period_end = tick_exp_end;
                end
                expected_samples.push_back(new_r);
            end
            if (cfg_valid && cfg_ready)
                write_model(cfg_index, cfg_data);
            if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure: m_ready is dropped for random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("multi_shape_waveform_generator_test failed");
        $finish;
    end

    task automatic send_tick(input logic adv, input logic typed,
                             input logic [7:0] es, input logic ee);
        int gap;
        if (idle_enable && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_advance       <= adv;
        tick_typed      <= typed;
        tick_exp_sample <= es;
        tick_exp_end    <= ee;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_ticks(input int count, input bit noisy);
        logic adv;
        repeat (count) begin
            adv = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) != 0);
            send_tick(adv, 1'b0, 8'h00, 1'b0);
        end
    endtask

    initial begin
        int         rand_items;
        int         len;
        logic [7:0] f;
        logic [2:0] sel;
        rand_items = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_reg(dir_rows[i].index, dir_rows[i].data);
            else
                send_tick(dir_rows[i].adv, dir_rows[i].typed,
                          dir_rows[i].exp_sample, dir_rows[i].exp_end);
        end

        // at least one full triangle period
        idle_enable <= 1'b1;
        write_reg(mswg_pkg::CFG_WAVE_SELECT, 8'(mswg_pkg::WAVE_TRI));
        repeat (520) send_tick(1'b1, 1'b0, 8'h00, 1'b0);

        while (rand_items < RAND_ITEMS) begin
            idle_enable <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0)
                write_reg(8'($urandom_range(2, 255)), 8'($urandom()));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0:       f = 8'd0;
                    1:       f = 8'd255;
                    2:       f = 8'($urandom_range(1, 8));
                    default: f = 8'($urandom());
                endcase
                write_reg(mswg_pkg::CFG_FREQUENCY, f);
            end
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 9) < 8)
                    sel = 3'($urandom_range(1, 4));
                else
                    sel = 3'($urandom_range(0, 7));
                write_reg(mswg_pkg::CFG_WAVE_SELECT, {5'($urandom()), sel});
            end
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(150, 220)
                                              : $urandom_range(5, 60);
            run_ticks(len, $urandom_range(0, 4) == 0);
            rand_items += len;
        end

        idle_enable <= 1'b0;
        run_ticks(60, 1'b0);

        wait_drained();
        repeat (4) @(posedge aclk);
        mismatches += expected_samples.size();
        if (mismatches == 0) begin
            $display("multi_shape_waveform_generator_test passed");
        end else begin
            $display("multi_shape_waveform_generator_test failed");
        end
        $finish;
    end

endmodule
